// ===== hw/rtl/ccx_pkg.sv =====
// ----------------------------------------------------------------------------
// ccx_pkg
// Shared types, constants and helpers for the ChaCha20 block XOR core.
// ----------------------------------------------------------------------------
package ccx_pkg;

    localparam int unsigned DOUBLE_ROUNDS_DEF = 10;
    localparam int unsigned STEPS_PER_DR      = 8;
    localparam int unsigned NUM_WORDS         = 16;
    localparam int unsigned NUM_DATA          = 8;

    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    typedef enum logic [2:0] {
        REG_KEY_0     = 3'd0,
        REG_KEY_1     = 3'd1,
        REG_KEY_2     = 3'd2,
        REG_KEY_3     = 3'd3,
        REG_NONCE_LO  = 3'd4,
        REG_NONCE_HI  = 3'd5,
        REG_START_CTR = 3'd6
    } ccx_reg_t;

    typedef struct packed {
        logic [63:0] in_word_0;
        logic [63:0] in_word_1;
        logic [63:0] in_word_2;
        logic [63:0] in_word_3;
        logic [63:0] in_word_4;
        logic [63:0] in_word_5;
        logic [63:0] in_word_6;
        logic [63:0] in_word_7;
        logic        restart;
    } ccx_in_t;

    typedef struct packed {
        logic [63:0] out_word_0;
        logic [63:0] out_word_1;
        logic [63:0] out_word_2;
        logic [63:0] out_word_3;
        logic [63:0] out_word_4;
        logic [63:0] out_word_5;
        logic [63:0] out_word_6;
        logic [63:0] out_word_7;
    } ccx_out_t;

    // one block in flight: working state, its counter, and the data to XOR
    typedef struct packed {
        logic [NUM_WORDS-1:0][31:0] w;
        logic [31:0]                ctr;
        logic [NUM_DATA-1:0][63:0]  data;
    } ccx_lane_t;

    function automatic int unsigned rot_amount(input int unsigned ph);
        int unsigned r;
        case (ph)
            0:       r = 16;
            1:       r = 12;
            2:       r = 8;
            default: r = 7;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned c);
        return (v << c) | (v >> (32 - c));
    endfunction

endpackage

// ===== hw/rtl/ccx_cell.sv =====
// ----------------------------------------------------------------------------
// ccx_cell
// One quarter-round step (add, xor, rotate) on all four columns or diagonals.
// ----------------------------------------------------------------------------
module ccx_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               lane_valid,
    input  ccx_pkg::ccx_lane_t lane,
    output logic               next_valid,
    output ccx_pkg::ccx_lane_t next_lane
);

    localparam int unsigned DIAG = STEP / 4;
    localparam int unsigned PH   = STEP % 4;
    localparam int unsigned ROT  = ccx_pkg::rot_amount(PH);

    logic               valid_reg;
    ccx_pkg::ccx_lane_t lane_reg;
    ccx_pkg::ccx_lane_t lane_next;

    always_comb
    begin
        logic [3:0]  ia;
        logic [3:0]  ib;
        logic [3:0]  ic;
        logic [3:0]  id;
        logic [31:0] sum;
        lane_next = lane;
        for (int k = 0; k < 4; k++)
        begin
            ia = 4'(k);
            ib = 4'(4 + ((k + DIAG) % 4));
            ic = 4'(8 + ((k + 2 * DIAG) % 4));
            id = 4'(12 + ((k + 3 * DIAG) % 4));
            if (PH == 0 || PH == 2)
            begin
                sum             = lane.w[ia] + lane.w[ib];
                lane_next.w[ia] = sum;
                lane_next.w[id] = ccx_pkg::rotl32(lane.w[id] ^ sum, ROT);
            end
            else
            begin
                sum             = lane.w[ic] + lane.w[id];
                lane_next.w[ic] = sum;
                lane_next.w[ib] = ccx_pkg::rotl32(lane.w[ib] ^ sum, ROT);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= lane_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            lane_reg <= lane_next;
    end

    assign next_valid = valid_reg;
    assign next_lane  = lane_reg;

endmodule

// ===== hw/rtl/ccx_final.sv =====
// ----------------------------------------------------------------------------
// ccx_final
// Feed-forward add, keystream XOR and output register with flow control.
// ----------------------------------------------------------------------------
module ccx_final (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  lane_valid,
    input  ccx_pkg::ccx_lane_t                    lane,
    input  logic [ccx_pkg::NUM_WORDS-1:0][31:0]   base_w,
    input  logic                                  stall,
    output logic                                  adv,
    output logic                                  out_valid,
    output ccx_pkg::ccx_out_t                     out_item
);

    logic                                 valid_reg;
    logic                                 valid_next;
    ccx_pkg::ccx_out_t                    item_reg;
    ccx_pkg::ccx_out_t                    item_next;
    logic [ccx_pkg::NUM_WORDS-1:0][31:0]  ks;
    logic [ccx_pkg::NUM_DATA-1:0][63:0]   res;

    assign adv = !lane_valid || !valid_reg || !stall;

    always_comb
    begin
        for (int i = 0; i < ccx_pkg::NUM_WORDS; i++)
        begin
            if (i == 12)
                ks[i] = lane.w[i] + lane.ctr;
            else
                ks[i] = lane.w[i] + base_w[i];
        end
        for (int j = 0; j < ccx_pkg::NUM_DATA; j++)
            res[j] = lane.data[j] ^ {ks[2 * j + 1], ks[2 * j]};
        item_next = {res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7]};
        valid_next = (lane_valid && adv) || (valid_reg && stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (lane_valid && adv)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== hw/rtl/chacha20_block_xor_core.sv =====
// ----------------------------------------------------------------------------
// chacha20_block_xor_core
// ChaCha20 keystream generation and XOR, one 64-byte block per clock unless stalled.
// ----------------------------------------------------------------------------
// Each accepted transfer carries one 64-byte block, and a new block is
// taken every cycle unless the chain halts. The result is registered in
// a chain of round cells: each cell does one add/xor/rotate step of the
// quarter round on all four columns or diagonals, eight cells per double
// round, followed by one output stage for the feed-forward add and XOR.
// The whole chain moves together; it halts only when the output register
// holds an untaken result and the last cell also holds a block. Key, nonce
// and start counter are written through the cfg port (always ready) and
// must not change while blocks are in flight.
// ----------------------------------------------------------------------------
module chacha20_block_xor_core #(
    parameter int unsigned DOUBLE_ROUNDS = ccx_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ccx_pkg::ccx_in_t  in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output ccx_pkg::ccx_out_t out_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data
);

    localparam int unsigned NUM_CELLS = DOUBLE_ROUNDS * ccx_pkg::STEPS_PER_DR;

    logic [63:0] key0_reg;
    logic [63:0] key1_reg;
    logic [63:0] key2_reg;
    logic [63:0] key3_reg;
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;
    logic [31:0] start_reg;
    logic [31:0] ctr_reg;
    logic [31:0] ctr_next;
    logic [31:0] cur_ctr;

    logic                                adv;
    logic                                accept;
    logic [ccx_pkg::NUM_WORDS-1:0][31:0] base_w;
    ccx_pkg::ccx_lane_t                  lane   [NUM_CELLS+1];
    logic                                lane_v [NUM_CELLS+1];

    assign cfg_ready = 1'b1;
    assign in_stall  = !adv;
    assign accept    = in_valid && adv;
    assign cur_ctr   = in_item.restart ? start_reg : ctr_reg;
    assign ctr_next  = accept ? cur_ctr + 32'd1 : ctr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg     <= '0;
            key1_reg     <= '0;
            key2_reg     <= '0;
            key3_reg     <= '0;
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
            start_reg    <= '0;
            ctr_reg      <= '0;
        end
        else
        begin
            ctr_reg <= ctr_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ccx_pkg::REG_KEY_0:     key0_reg     <= cfg_data;
                    ccx_pkg::REG_KEY_1:     key1_reg     <= cfg_data;
                    ccx_pkg::REG_KEY_2:     key2_reg     <= cfg_data;
                    ccx_pkg::REG_KEY_3:     key3_reg     <= cfg_data;
                    ccx_pkg::REG_NONCE_LO:  nonce_lo_reg <= cfg_data;
                    ccx_pkg::REG_NONCE_HI:  nonce_hi_reg <= cfg_data[31:0];
                    ccx_pkg::REG_START_CTR: start_reg    <= cfg_data[31:0];
                    default:                ;
                endcase
            end
        end
    end

    always_comb
    begin
        base_w[0]  = ccx_pkg::SIGMA_0;
        base_w[1]  = ccx_pkg::SIGMA_1;
        base_w[2]  = ccx_pkg::SIGMA_2;
        base_w[3]  = ccx_pkg::SIGMA_3;
        base_w[4]  = key0_reg[31:0];
        base_w[5]  = key0_reg[63:32];
        base_w[6]  = key1_reg[31:0];
        base_w[7]  = key1_reg[63:32];
        base_w[8]  = key2_reg[31:0];
        base_w[9]  = key2_reg[63:32];
        base_w[10] = key3_reg[31:0];
        base_w[11] = key3_reg[63:32];
        base_w[12] = cur_ctr;
        base_w[13] = nonce_lo_reg[31:0];
        base_w[14] = nonce_lo_reg[63:32];
        base_w[15] = nonce_hi_reg;

        lane[0].w       = base_w;
        lane[0].ctr     = cur_ctr;
        lane[0].data[0] = in_item.in_word_0;
        lane[0].data[1] = in_item.in_word_1;
        lane[0].data[2] = in_item.in_word_2;
        lane[0].data[3] = in_item.in_word_3;
        lane[0].data[4] = in_item.in_word_4;
        lane[0].data[5] = in_item.in_word_5;
        lane[0].data[6] = in_item.in_word_6;
        lane[0].data[7] = in_item.in_word_7;
        lane_v[0]       = in_valid;
    end

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        ccx_cell #(
            .STEP (g % ccx_pkg::STEPS_PER_DR)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .lane_valid (lane_v[g]),
            .lane       (lane[g]),
            .next_valid (lane_v[g+1]),
            .next_lane  (lane[g+1])
        );
    end

    ccx_final u_final (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_valid (lane_v[NUM_CELLS]),
        .lane       (lane[NUM_CELLS]),
        .base_w     (base_w),
        .stall      (out_stall),
        .adv        (adv),
        .out_valid  (out_valid),
        .out_item   (out_item)
    );

endmodule

// ===== hw/rtl/ccx_checker.sv =====
// ----------------------------------------------------------------------------
// ccx_checker
// Port-level checks for the ChaCha20 block XOR core, bound to the top level.
// ----------------------------------------------------------------------------
module ccx_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input ccx_pkg::ccx_out_t out_item,
    input logic              cfg_ready
);

    // a held result stays put until transferred
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("output result changed or dropped while stalled");

    // upstream backpressure only when a result is blocked at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked output");

    // an empty or draining output never stalls the input
    a_no_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && (!out_valid || !out_stall) |-> !in_stall)
        else $error("input stalled while output can move");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind chacha20_block_xor_core ccx_checker u_ccx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_ready (cfg_ready)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for chacha20_block_xor_core. A short table of directed
// blocks and register writes, then random blocks under three stall profiles,
// each transfer checked against a ChaCha20 keystream model kept in the bench.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DR          = ccx_pkg::DOUBLE_ROUNDS_DEF;
    localparam int PIPE_DEPTH  = 8 * DR + 1;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 170;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef logic [0:7][63:0]  data_words_t;
    typedef logic [15:0][31:0] chacha_state_t;

    typedef struct {
        bit                is_write;
        logic [2:0]        idx;
        logic [63:0]       value;
        ccx_pkg::ccx_in_t  blk;
    } step_row_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    ccx_pkg::ccx_in_t  in_item   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    ccx_pkg::ccx_out_t out_item;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [2:0]        cfg_index = '0;
    logic [63:0]       cfg_data  = '0;

    logic [63:0]       cipher_regs [7];
    logic [31:0]       block_ctr;
    ccx_pkg::ccx_out_t pending_xor [$];
    int                errors      = 0;
    int                blocks_done = 0;
    int                reg_writes  = 0;
    int                restarts    = 0;
    int                send_idle   = 10;
    int                recv_idle   = 52;
    bit                hold_req    = 1'b0;

    chacha20_block_xor_core #(
        .DOUBLE_ROUNDS(DR)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("%0t: timeout, %0d blocks still pending", $time, pending_xor.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic chacha_state_t quarter_round(input chacha_state_t x,
        input int a, input int b, input int c, input int d);
        x[a] = x[a] + x[b];
        x[d] = rol32(x[d] ^ x[a], 16);
        x[c] = x[c] + x[d];
        x[b] = rol32(x[b] ^ x[c], 12);
        x[a] = x[a] + x[b];
        x[d] = rol32(x[d] ^ x[a], 8);
        x[c] = x[c] + x[d];
        x[b] = rol32(x[b] ^ x[c], 7);
        return x;
    endfunction

    function automatic ccx_pkg::ccx_out_t chacha_xor_block(input ccx_pkg::ccx_in_t blk,
        input logic [31:0] ctr);
        chacha_state_t init;
        chacha_state_t w;
        data_words_t   d;
        data_words_t   o;
        init[0] = ccx_pkg::SIGMA_0;
        init[1] = ccx_pkg::SIGMA_1;
        init[2] = ccx_pkg::SIGMA_2;
        init[3] = ccx_pkg::SIGMA_3;
        for (int i = 0; i < 4; i++)
        begin
            init[4 + 2 * i] = cipher_regs[i][31:0];
            init[5 + 2 * i] = cipher_regs[i][63:32];
        end
        init[12] = ctr;
        init[13] = cipher_regs[ccx_pkg::REG_NONCE_LO][31:0];
        init[14] = cipher_regs[ccx_pkg::REG_NONCE_LO][63:32];
        init[15] = cipher_regs[ccx_pkg::REG_NONCE_HI][31:0];
        w = init;
        for (int r = 0; r < DR; r++)
        begin
            w = quarter_round(w, 0, 4, 8, 12);
            w = quarter_round(w, 1, 5, 9, 13);
            w = quarter_round(w, 2, 6, 10, 14);
            w = quarter_round(w, 3, 7, 11, 15);
            w = quarter_round(w, 0, 5, 10, 15);
            w = quarter_round(w, 1, 6, 11, 12);
            w = quarter_round(w, 2, 7, 8, 13);
            w = quarter_round(w, 3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++)
            w[i] = w[i] + init[i];
        d = {blk.in_word_0, blk.in_word_1, blk.in_word_2, blk.in_word_3,
             blk.in_word_4, blk.in_word_5, blk.in_word_6, blk.in_word_7};
        for (int i = 0; i < 8; i++)
            o[i] = d[i] ^ {w[2 * i + 1], w[2 * i]};
        return o;
    endfunction

    // shadow registers, block counter, and checking of every transfer
    always @(posedge clk)
    begin
        data_words_t e;
        data_words_t a;
        if (!rst_n)
        begin
            for (int i = 0; i < 7; i++)
                cipher_regs[i] = '0;
            block_ctr = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                if (cfg_index <= ccx_pkg::REG_START_CTR)
                    cipher_regs[cfg_index] = (cfg_index >= ccx_pkg::REG_NONCE_HI) ?
                                             {32'h0, cfg_data[31:0]} : cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                if (in_item.restart)
                begin
                    block_ctr = cipher_regs[ccx_pkg::REG_START_CTR][31:0];
                    restarts++;
                end
                pending_xor.push_back(chacha_xor_block(in_item, block_ctr));
                block_ctr = block_ctr + 32'd1;
            end
            if (out_valid && !out_stall)
            begin
                if (pending_xor.size() == 0)
                begin
                    errors++;
                    $display("%0t: expected no result, actual %h", $time, out_item);
                end
                else
                begin
                    e = pending_xor.pop_front();
                    a = out_item;
                    for (int i = 0; i < 8; i++)
                        if (a[i] !== e[i])
                        begin
                            errors++;
                            $display("%0t: out_word_%0d expected %h actual %h",
                                     $time, i, e[i], a[i]);
                        end
                    blocks_done++;
                end
            end
        end
    end

    // output side: random stall, or a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle);
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic ccx_pkg::ccx_in_t rand_block();
        data_words_t      d;
        ccx_pkg::ccx_in_t b;
        for (int i = 0; i < 8; i++)
            d[i] = rand_word();
        b = {d, 1'b0};
        b.restart = ($urandom_range(0, 7) == 0);
        return b;
    endfunction

    function automatic step_row_t blk_row(input logic [63:0] even, input logic [63:0] odd,
        input logic rs);
        step_row_t r;
        r.is_write = 1'b0;
        r.idx      = '0;
        r.value    = '0;
        r.blk      = {even, odd, even, odd, even, odd, even, odd, rs};
        return r;
    endfunction

    function automatic step_row_t reg_row(input logic [2:0] idx, input logic [63:0] value);
        step_row_t r;
        r.is_write = 1'b1;
        r.idx      = idx;
        r.value    = value;
        r.blk      = '0;
        return r;
    endfunction

    task automatic put_block(input ccx_pkg::ccx_in_t blk);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= blk;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_xor.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        step_row_t rows [$];
        bit        prev_write;

        // zero key and counter after reset, then all-ones key, nonce and
        // start counter for the counter wrap, then the RFC 8439 key/nonce
        rows.push_back(blk_row(64'h0, 64'h0, 1'b0));
        rows.push_back(blk_row('1, '1, 1'b0));
        rows.push_back(blk_row(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1));
        rows.push_back(reg_row(ccx_pkg::REG_KEY_0, '1));
        rows.push_back(reg_row(ccx_pkg::REG_KEY_1, '1));
        rows.push_back(reg_row(ccx_pkg::REG_KEY_2, '1));
        rows.push_back(reg_row(ccx_pkg::REG_KEY_3, '1));
        rows.push_back(reg_row(ccx_pkg::REG_NONCE_LO, '1));
        rows.push_back(reg_row(ccx_pkg::REG_NONCE_HI, '1));
        rows.push_back(reg_row(ccx_pkg::REG_START_CTR, '1));
        rows.push_back(reg_row(REG_UNUSED, 64'h0123_4567_89AB_CDEF));
        rows.push_back(blk_row(64'h0, 64'h0, 1'b1));
        rows.push_back(blk_row(64'h0, 64'h0, 1'b0));
        rows.push_back(blk_row('1, 64'h0, 1'b0));
        rows.push_back(reg_row(ccx_pkg::REG_KEY_0, 64'h0706_0504_0302_0100));
        rows.push_back(reg_row(ccx_pkg::REG_KEY_1, 64'h0F0E_0D0C_0B0A_0908));
        rows.push_back(reg_row(ccx_pkg::REG_KEY_2, 64'h1716_1514_1312_1110));
        rows.push_back(reg_row(ccx_pkg::REG_KEY_3, 64'h1F1E_1D1C_1B1A_1918));
        rows.push_back(reg_row(ccx_pkg::REG_NONCE_LO, 64'h4A00_0000_0900_0000));
        rows.push_back(reg_row(ccx_pkg::REG_NONCE_HI, 64'hFFFF_FFFF_0000_0000));
        rows.push_back(reg_row(ccx_pkg::REG_START_CTR, 64'hFFFF_FFFF_0000_0001));
        rows.push_back(blk_row(64'h0, 64'h0, 1'b1));
        rows.push_back(blk_row(64'h0, 64'h0, 1'b1));
        rows.push_back(blk_row(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0));
        rows.push_back(blk_row('1, '1, 1'b1));
        rows.push_back(reg_row(REG_UNUSED, '1));
        rows.push_back(reg_row(ccx_pkg::REG_KEY_0, 64'h0));
        rows.push_back(reg_row(ccx_pkg::REG_START_CTR, 64'h0000_0000_7FFF_FFFF));
        rows.push_back(blk_row(64'h0, '1, 1'b1));
        rows.push_back(blk_row(64'h0, 64'h0, 1'b0));

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        prev_write = 1'b0;
        foreach (rows[i])
        begin
            if (rows[i].is_write)
            begin
                if (!prev_write)
                    wait_drained();
                write_reg(rows[i].idx, rows[i].value);
            end
            else
                put_block(rows[i].blk);
            prev_write = rows[i].is_write;
        end

        for (int p = 0; p < 3; p++)
        begin
            send_idle = (p == 0) ? 10 : (p == 1) ? 52 : 0;
            recv_idle = (p == 0) ? 52 : (p == 1) ? 10 : 0;
            wait_drained();
            for (int r = 0; r <= ccx_pkg::REG_START_CTR; r++)
                write_reg(r[2:0], rand_word());
            write_reg(3'($urandom_range(0, 7)), rand_word());
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 2 && n == 40)
                    hold_req = 1'b1;
                if ((p == 0 && n == 90) || (p == 2 && n == 130))
                    wait_drained();
                put_block(rand_block());
            end
        end

        wait_drained();
        repeat (PIPE_DEPTH + 20) @(negedge clk);

        $display("%0d blocks checked over %0d register writes and %0d counter restarts,",
                 blocks_done, reg_writes, restarts);
        $display("with sender/receiver stalls, a %0d-cycle output hold-off and drains.",
                 HOLD_CYCLES);
        if (errors == 0 && pending_xor.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
